// ===== hw/rtl/tsms_pkg.sv =====
// ----------------------------------------------------------------------------
// tsms_pkg: shared types and constants
// Action codes, field widths and the control/status structs that pass
// between the top level and the cell row.
// ----------------------------------------------------------------------------
package tsms_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int VALUE_W      = 64;
    localparam int ACT_W        = 2;
    localparam int SIZE_W       = 8;
    localparam int UNION_W      = 9;
    localparam int OUT_DATA_W   = 40;

    localparam logic [ACT_W-1:0] ACT_ADD_A = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_B = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    // control from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;   // register match flags against the incoming value
        logic shift_a;  // push a new entry into the A column
        logic shift_b;  // push a new entry into the B column
    } t_row_ctrl;

    // reduced match flags back from the row
    typedef struct packed {
        logic hit_a;
        logic hit_b;
    } t_row_hit;

endpackage

// ===== hw/rtl/tsms_cell.sv =====
// ----------------------------------------------------------------------------
// tsms_cell: one storage slot of each set
// Holds one A entry and one B entry, compares both against the broadcast
// value and shifts its entries on to the next cell on an insert.
// ----------------------------------------------------------------------------
module tsms_cell
    import tsms_pkg::*;
(
    input  logic               i_clk,
    input  t_row_ctrl          i_ctrl,
    input  logic [VALUE_W-1:0] i_value,    // value to compare
    input  logic [VALUE_W-1:0] i_prev_a,   // entry from the previous cell
    input  logic [VALUE_W-1:0] i_prev_b,
    input  logic               i_valid_a,  // slot lies below the A fill count
    input  logic               i_valid_b,
    output logic [VALUE_W-1:0] o_entry_a,
    output logic [VALUE_W-1:0] o_entry_b,
    output logic               o_match_a,
    output logic               o_match_b
);

    logic [VALUE_W-1:0] r_entry_a;
    logic [VALUE_W-1:0] r_entry_b;
    logic               r_match_a;
    logic               r_match_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_a) begin
            r_entry_a <= i_prev_a;
        end
        if (i_ctrl.shift_b) begin
            r_entry_b <= i_prev_b;
        end
        if (i_ctrl.cmp_en) begin
            r_match_a <= i_valid_a && (r_entry_a == i_value);
            r_match_b <= i_valid_b && (r_entry_b == i_value);
        end
    end

    assign o_entry_a = r_entry_a;
    assign o_entry_b = r_entry_b;
    assign o_match_a = r_match_a;
    assign o_match_b = r_match_b;

endmodule

// ===== hw/rtl/tsms_row.sv =====
// ----------------------------------------------------------------------------
// tsms_row: chain of storage cells
// New entries enter at cell 0 and ripple one cell down; match flags from all
// cells are ORed into one hit per set.
// ----------------------------------------------------------------------------
module tsms_row
    import tsms_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                          i_clk,
    input  t_row_ctrl                     i_ctrl,
    input  logic [VALUE_W-1:0]            i_value,   // compare value
    input  logic [VALUE_W-1:0]            i_ins,     // value pushed into cell 0
    input  logic [$clog2(CAPACITY+1)-1:0] i_count_a,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count_b,
    output t_row_hit                      o_hit
);

    localparam int CNT_W = $clog2(CAPACITY+1);

    logic [VALUE_W-1:0]  w_entry_a [CAPACITY];
    logic [VALUE_W-1:0]  w_entry_b [CAPACITY];
    logic [CAPACITY-1:0] w_match_a;
    logic [CAPACITY-1:0] w_match_b;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_W-1:0] w_prev_a;
            logic [VALUE_W-1:0] w_prev_b;

            if (g == 0) begin : g_head
                assign w_prev_a = i_ins;
                assign w_prev_b = i_ins;
            end else begin : g_link
                assign w_prev_a = w_entry_a[g-1];
                assign w_prev_b = w_entry_b[g-1];
            end

            tsms_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (i_ctrl),
                .i_value   (i_value),
                .i_prev_a  (w_prev_a),
                .i_prev_b  (w_prev_b),
                .i_valid_a (CNT_W'(g) < i_count_a),
                .i_valid_b (CNT_W'(g) < i_count_b),
                .o_entry_a (w_entry_a[g]),
                .o_entry_b (w_entry_b[g]),
                .o_match_a (w_match_a[g]),
                .o_match_b (w_match_b[g])
            );
        end
    endgenerate

    assign o_hit.hit_a = |w_match_a;
    assign o_hit.hit_b = |w_match_b;

endmodule

// ===== hw/rtl/two_set_membership_store.sv =====
// ----------------------------------------------------------------------------
// two_set_membership_store: two bounded sets of 64-bit values
// Add to A, add to B, membership query and clear, with set sizes,
// intersection, union and subset flags on every result item.
// ----------------------------------------------------------------------------
// Each item runs in a compare step and an update step. On acceptance every
// cell of the row compares its stored A and B entries with the incoming value
// and registers a match flag; in the update state the flags are ORed, the
// counts are updated, a new entry is pushed into the head of the row and the
// result is loaded into the output register. A new item is taken once the row
// is idle and the output register is empty or being drained. Both stores hold
// no reset value; only slots below each fill count take part in a compare, so
// a clear only zeroes the counts, in the same way as any other item, and needs
// no sweep.
// Entries are kept in insertion order, newest at cell 0.
// ----------------------------------------------------------------------------
module two_set_membership_store
    import tsms_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VALUE_W-1:0]    i_s_tdata,   // [63:0] value
    input  logic [ACT_W-1:0]      i_s_tuser,   // [1:0] action
    // result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] in_a, [1] in_b, [2] added, [3] set_full, [11:4] size_a,
    // [19:12] size_b, [27:20] shared_count, [36:28] union_size,
    // [37] a_within_b, [38] b_within_a, [39] zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY+1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                  r_state;
    logic [ACT_W-1:0]      r_act;
    logic [VALUE_W-1:0]    r_val;
    logic [CNT_W-1:0]      r_count_a;
    logic [CNT_W-1:0]      r_count_b;
    logic [CNT_W-1:0]      r_common;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]      n_count_a;
    logic [CNT_W-1:0]      n_count_b;
    logic [CNT_W-1:0]      n_common;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic       w_in_acc;
    logic       w_upd;
    t_row_ctrl  w_ctrl;
    t_row_hit   w_hit;

    logic w_is_add_a, w_is_add_b, w_is_clear;
    logic w_full_a, w_full_b;
    logic w_ins_a, w_ins_b;
    logic w_refused;
    logic w_in_a, w_in_b;
    logic [CNT_W:0] w_union;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_upd      = (r_state == ST_UPD);

    // ---- cell row ----------------------------------------------------------
    assign w_ctrl.cmp_en  = w_in_acc;
    assign w_ctrl.shift_a = w_upd && w_ins_a;
    assign w_ctrl.shift_b = w_upd && w_ins_b;

    tsms_row #(
        .CAPACITY (CAPACITY)
    ) u_row (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_value   (i_s_tdata),
        .i_ins     (r_val),
        .i_count_a (r_count_a),
        .i_count_b (r_count_b),
        .o_hit     (w_hit)
    );

    // ---- update step -------------------------------------------------------
    always_comb begin
        w_is_add_a = (r_act == ACT_ADD_A);
        w_is_add_b = (r_act == ACT_ADD_B);
        w_is_clear = (r_act == ACT_CLEAR);
        w_full_a   = (r_count_a == CNT_W'(CAPACITY));
        w_full_b   = (r_count_b == CNT_W'(CAPACITY));

        // insert only when absent from the target set and there is room
        w_ins_a   = w_is_add_a && !w_hit.hit_a && !w_full_a;
        w_ins_b   = w_is_add_b && !w_hit.hit_b && !w_full_b;
        w_refused = (w_is_add_a && !w_hit.hit_a && w_full_a) ||
                    (w_is_add_b && !w_hit.hit_b && w_full_b);

        if (w_is_clear) begin
            n_count_a = '0;
            n_count_b = '0;
            n_common  = '0;
            w_in_a    = 1'b0;
            w_in_b    = 1'b0;
        end else begin
            n_count_a = r_count_a + CNT_W'(w_ins_a);
            n_count_b = r_count_b + CNT_W'(w_ins_b);
            // a fresh entry that is already in the other set joins the overlap
            n_common  = r_common + CNT_W'((w_ins_a && w_hit.hit_b) ||
                                          (w_ins_b && w_hit.hit_a));
            w_in_a    = w_hit.hit_a || w_ins_a;
            w_in_b    = w_hit.hit_b || w_ins_b;
        end

        w_union = (CNT_W+1)'(n_count_a) + (CNT_W+1)'(n_count_b)
                - (CNT_W+1)'(n_common);

        n_out_data = {1'b0,
                      (n_common == n_count_b),
                      (n_common == n_count_a),
                      UNION_W'(w_union),
                      SIZE_W'(n_common),
                      SIZE_W'(n_count_b),
                      SIZE_W'(n_count_a),
                      w_refused,
                      (w_ins_a || w_ins_b),
                      w_in_b,
                      w_in_a};
    end

    // ---- control registers -------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_common    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_state   <= ST_IDLE;
                    r_count_a <= n_count_a;
                    r_count_b <= n_count_b;
                    r_common  <= n_common;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers -------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act <= i_s_tuser;
            r_val <= i_s_tdata;
        end
        if (w_upd) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---- assertions --------------------------------------------------------
    // overlap can never outgrow either set
    a_common_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_common <= r_count_a) && (r_common <= r_count_b))
        else $error("overlap count exceeds a set size");

    // an accepted item is always followed by its update cycle
    a_acc_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_UPD))
        else $error("accepted item did not reach the update cycle");

    // a set grows by at most one entry per item, or is cleared
    a_grow_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count_a != $past(r_count_a)) |->
            ((r_count_a == $past(r_count_a) + 1'b1) || (r_count_a == '0)))
        else $error("set A count jumped");

    // the update cycle never finds the output register occupied
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd |-> !r_out_valid)
        else $error("result overwritten before it was taken");

endmodule
